[rtl/igc_pkg.sv]
// ----------------------------------------------------------------------------
// igc_pkg
// shared types and constants for the interference graph colouring block
// ----------------------------------------------------------------------------
package igc_pkg;
    localparam int MAX_NODES_DEF = 64;
    localparam int ID_BITS_DEF   = 32;
    localparam int SLOT_W        = 6;
    localparam int COLOR_W       = 7;
    localparam int DEG_W         = 8;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [1:0] OP_ADD_NODE  = 2'd0;
    localparam logic [1:0] OP_ADD_NEIGH = 2'd1;
    localparam logic [1:0] OP_ADD_OUT   = 2'd2;
    localparam logic [1:0] OP_RUN       = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [63:0]       id;
        logic [SLOT_W-1:0] ns;
        logic [SLOT_W-1:0] nb;
    } t_cmd;
endpackage

[rtl/igc_front.sv]
// ----------------------------------------------------------------------------
// igc_front
// command intake, range check against the loaded node count, small queue
// ----------------------------------------------------------------------------
module igc_front
    import igc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_cmd              i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output t_cmd              o_cmd
);
    localparam int QA = $clog2(QUEUE_DEPTH);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QA-1:0]   r_wp, r_rp;
    logic [QA:0]     r_cnt;
    logic [6:0]      r_total;
    logic            keep;

    // drop items the model would ignore, track node count as loaded
    always_comb begin
        keep = 1'b1;
        case (i_cmd.op)
            OP_ADD_NODE:  keep = (r_total < 7'(MAX_NODES));
            OP_ADD_NEIGH: keep = (7'(i_cmd.ns) < r_total) && (7'(i_cmd.nb) < r_total);
            OP_ADD_OUT:   keep = (7'(i_cmd.ns) < r_total);
            default:      keep = 1'b1;
        endcase
    end

    wire do_push = i_push && keep;

    assign o_full  = (r_cnt >= (QA+1)'(QUEUE_DEPTH - 1));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_total <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (i_pop)   r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QA+1)'(do_push) - (QA+1)'(i_pop);
            if (i_push) begin
                if (i_cmd.op == OP_RUN) r_total <= '0;
                else if (do_push && i_cmd.op == OP_ADD_NODE) r_total <= r_total + 1'b1;
            end
        end
    end
endmodule

[rtl/igc_back.sv]
// ----------------------------------------------------------------------------
// igc_back
// graph store, elimination and colouring sequencer
// ----------------------------------------------------------------------------
module igc_back
    import igc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_idle,
    output logic               o_strobe,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [31:0]        o_id,
    output logic [COLOR_W-1:0] o_color,
    output logic               o_last,
    output logic               o_empty
);
    localparam int N  = MAX_NODES;
    localparam int SA = $clog2(N);

    localparam logic [3:0] S_IDLE  = 4'd0, S_LOAD = 4'd1, S_PICK = 4'd2, S_CLR   = 4'd3,
                           S_DEC   = 4'd4, S_CRD  = 4'd5, S_CROW = 4'd6, S_CSCAN = 4'd7,
                           S_CEMIT = 4'd8;

    logic [3:0]          r_st;
    logic [ID_BITS-1:0]  r_ids [N];
    logic [N-1:0]        r_adj [N];
    logic [DEG_W-1:0]    r_deg [N];
    logic [SA-1:0]       r_order [N];
    logic [COLOR_W-1:0]  r_col [N];
    logic [ID_BITS-1:0]  r_id_q;
    logic [N-1:0]        r_adj_q;
    logic [DEG_W-1:0]    r_deg_q;
    logic [SA-1:0]       r_ord_q;
    logic [COLOR_W-1:0]  r_col_q;
    logic [6:0]          r_total;
    logic [N-1:0]        r_removed, r_coloured;
    logic [6:0]          r_k, r_i;
    logic [SA-1:0]       r_best, r_cur;
    logic [8:0]          r_bdeg;
    logic [64:0]         r_used;
    logic [1:0]          r_ld_op;
    logic [SA-1:0]       r_ld_ns, r_ld_nb;
    logic [SA-1:0]       ns, nb, ii, pj, deg_ra, adj_ra;
    logic [6:0]          im1;
    logic [N-1:0]        set_row;
    logic [6:0]          free_c;
    logic                emit_now;

    assign ns  = i_cmd.ns[SA-1:0];
    assign nb  = i_cmd.nb[SA-1:0];
    assign ii  = r_i[SA-1:0];
    assign im1 = r_i - 7'd1;
    assign pj  = im1[SA-1:0];
    assign o_idle = (r_st == S_IDLE);
    assign o_pop  = i_valid && (r_st == S_IDLE);

    assign emit_now = (r_st == S_CEMIT) ||
                      (r_st == S_IDLE && i_valid && i_cmd.op == OP_RUN && r_total == '0);

    // scans read one slot a cycle, the registered data is used in the next cycle
    assign deg_ra = (r_st == S_IDLE) ? ns : ii;

    always_comb begin
        case (r_st)
            S_IDLE:       adj_ra = ns;
            S_CLR, S_DEC: adj_ra = r_best;
            S_CROW:       adj_ra = r_ord_q;
            default:      adj_ra = r_cur;
        endcase
    end

    always_comb begin
        set_row = r_adj_q;
        set_row[r_ld_nb] = 1'b1;
    end

    // lowest clear bit of the used-colour set
    always_comb begin
        free_c = 7'd64;
        for (int c = 63; c >= 0; c--) if (!r_used[c]) free_c = 7'(c);
    end

    // registered store reads
    always_ff @(posedge i_clk) begin
        r_deg_q <= r_deg[deg_ra];
        r_adj_q <= r_adj[adj_ra];
        r_col_q <= r_col[ii];
        r_ord_q <= r_order[r_k[SA-1:0]];
        r_id_q  <= r_ids[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
            r_st <= S_IDLE; r_total <= '0; r_removed <= '0; r_coloured <= '0;
        end else begin
            o_strobe <= emit_now;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    case (i_cmd.op)
                        OP_ADD_NODE: begin
                            r_ids[r_total[SA-1:0]] <= i_cmd.id[ID_BITS-1:0];
                            r_adj[r_total[SA-1:0]] <= '0;
                            r_deg[r_total[SA-1:0]] <= '0;
                            r_total <= r_total + 1'b1;
                        end
                        OP_ADD_NEIGH, OP_ADD_OUT: begin
                            r_ld_op <= i_cmd.op; r_ld_ns <= ns; r_ld_nb <= nb;
                            r_st <= S_LOAD;
                        end
                        default: begin
                            if (r_total == '0) begin
                                o_slot <= '0; o_id <= '0;
                                o_color <= '0; o_last <= 1'b0; o_empty <= 1'b1;
                            end else begin
                                r_removed <= '0; r_k <= '0; r_i <= '0;
                                r_bdeg <= '1; r_best <= '0; r_st <= S_PICK;
                            end
                        end
                    endcase
                end
                S_LOAD: begin
                    // row and degree of the slot were read in the idle cycle
                    if (r_ld_op == OP_ADD_NEIGH) begin
                        if (!r_adj_q[r_ld_nb]) begin
                            r_adj[r_ld_ns] <= set_row;
                            if (r_deg_q != '1) r_deg[r_ld_ns] <= r_deg_q + 1'b1;
                        end
                    end else if (r_deg_q != '1) begin
                        r_deg[r_ld_ns] <= r_deg_q + 1'b1;
                    end
                    r_st <= S_IDLE;
                end
                S_PICK: begin
                    if (r_i != '0 && !r_removed[pj] &&
                        (r_bdeg == '1 || {1'b0, r_deg_q} > r_bdeg)) begin
                        r_bdeg <= {1'b0, r_deg_q}; r_best <= pj;
                    end
                    if (r_i == r_total) r_st <= S_CLR;
                    else r_i <= r_i + 1'b1;
                end
                S_CLR: begin
                    r_order[r_k[SA-1:0]] <= r_best;
                    r_removed[r_best] <= 1'b1;
                    r_i <= '0; r_st <= S_DEC;
                end
                S_DEC: begin
                    if (r_i != '0 && r_adj_q[pj] && !r_removed[pj] && r_deg_q != '0)
                        r_deg[pj] <= r_deg_q - 1'b1;
                    if (r_i == r_total) begin
                        r_i <= '0; r_bdeg <= '1; r_best <= '0;
                        if (r_k == r_total - 1'b1) begin
                            r_coloured <= '0; r_st <= S_CRD;
                        end else begin
                            r_k <= r_k + 1'b1; r_st <= S_PICK;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_CRD: r_st <= S_CROW;
                S_CROW: begin
                    r_cur <= r_ord_q;
                    r_used <= '0; r_i <= '0; r_st <= S_CSCAN;
                end
                S_CSCAN: begin
                    if (r_i != '0 && r_adj_q[pj] && r_coloured[pj]) r_used[r_col_q] <= 1'b1;
                    if (r_i == r_total) r_st <= S_CEMIT;
                    else r_i <= r_i + 1'b1;
                end
                S_CEMIT: begin
                    r_col[r_cur] <= free_c;
                    r_coloured[r_cur] <= 1'b1;
                    o_slot <= SLOT_W'(r_cur);
                    o_id <= 32'(r_id_q);
                    o_color <= free_c;
                    o_last <= (r_k == '0);
                    o_empty <= 1'b0;
                    if (r_k == '0) begin
                        r_total <= '0; r_st <= S_IDLE;
                    end else begin
                        r_k <= r_k - 1'b1; r_st <= S_CRD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/interference_graph_greedy_coloring.sv]
// ----------------------------------------------------------------------------
// interference_graph_greedy_coloring
// loads a graph beat by beat and colours it by max-degree elimination
// ----------------------------------------------------------------------------
// Load beats enter a four-entry queue at up to one per cycle; the back part
// takes an add node beat in its idle state, while a neighbour beat also
// passes a load state, which reads the slot's row and degree before writing
// them back. busy rises when three beats are queued and stays high while a
// run is queued or in progress. Once the run beat is taken from the queue,
// elimination and then colouring run for N loaded nodes, with one slot scan
// per pick, one per degree update and one per colour. Results come one per
// strobe and cannot be stalled; the last carries o_last, an empty run gives
// one result with o_empty_res.
module interference_graph_greedy_coloring
    import igc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_node_id,
    input  logic [SLOT_W-1:0]  i_node_slot,
    input  logic [SLOT_W-1:0]  i_neighbor_slot,
    output logic               o_strobe,
    output logic [SLOT_W-1:0]  o_out_slot,
    output logic [31:0]        o_out_id,
    output logic [COLOR_W-1:0] o_out_color,
    output logic               o_last,
    output logic               o_empty_res
);
    t_cmd cmd, q_cmd;
    logic full, q_valid, pop, idle, r_run;

    assign cmd = '{op: i_opcode, id: 64'(i_node_id), ns: i_node_slot, nb: i_neighbor_slot};

    // hold off while a run is queued or in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_run <= 1'b0;
        else if (start && !busy && i_opcode == OP_RUN) r_run <= 1'b1;
        else if (idle && !q_valid) r_run <= 1'b0;
    end
    assign busy = full || r_run;

    igc_front #(.MAX_NODES(MAX_NODES)) u_front (
        .i_clk, .i_rst_n, .i_push(start && !busy), .i_cmd(cmd),
        .i_pop(pop), .o_full(full), .o_valid(q_valid), .o_cmd(q_cmd));

    igc_back #(.MAX_NODES(MAX_NODES), .ID_BITS(ID_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .o_idle(idle), .o_strobe, .o_slot(o_out_slot), .o_id(o_out_id),
        .o_color(o_out_color), .o_last, .o_empty(o_empty_res));
endmodule
